// ===== hdl/pgstc_pkg.sv =====
// Package for the prefix-gated source tag classifier.
// Holds request/result structs, function and status codes, and the FSM state type.
package pgstc_pkg;

  localparam logic [1:0] FUNC_CLASSIFY = 2'd0;
  localparam logic [1:0] FUNC_ADD_CLIENT = 2'd1;
  localparam logic [1:0] FUNC_ADD_PREFIX = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;
  localparam logic [1:0] FAM_OTHER = 2'd2;
  localparam logic [1:0] FAM_RESERVED = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;
  localparam logic [1:0] ST_DUP = 2'd3;

  localparam logic [15:0] V4_MAX_LEN = 16'd32;
  localparam logic [15:0] V6_MAX_LEN = 16'd128;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  family;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] number;
    logic        from_lan_edge;
    logic        flow_tracked;
    logic        reply_direction;
  } req_t;

  typedef struct packed {
    logic [15:0] qos_tag;
    logic        tag_write;
    logic        write_reply_field;
    logic        dest_local;
    logic [1:0]  status;
  } res_t;

  // Stored entry: address, family flag and tag or prefix length.
  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        is_v6;
    logic [15:0] num;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PSCAN,
    S_CSCAN,
    S_WRITE,
    S_DONE
  } state_t;

  // Prefix compare; len is already limited to the family's maximum.
  function automatic logic prefix_hit(input logic v6, input logic [127:0] a,
                                      input logic [127:0] p, input logic [7:0] len);
    logic [127:0] m;
    logic [31:0]  m4;
    m  = '0;
    m4 = '0;
    if (len == 8'd0) return 1'b1;
    if (!v6) begin
      m4 = 32'hFFFF_FFFF << (6'd32 - len[5:0]);
      return ((a[31:0] ^ p[31:0]) & m4) == 32'd0;
    end
    m = {128{1'b1}} << (8'd128 - len);
    return ((a ^ p) & m) == 128'd0;
  endfunction

endpackage

// ===== hdl/prefix_gated_source_tag_classifier_core.sv =====
// Prefix-gated source tag classifier: local prefix table and client tag table in RAM.
// Classify scans the prefix table and, without a hit, the client table; a load scans
// its own table, then writes if accepted; clear goes straight to done. One request at
// a time, busy meanwhile. Each scan reads one entry a cycle. Reset (synchronous, rst_n
// low) zeroes both counts; RAM contents need no clearing. Results appear for one cycle
// with out_valid; the receiver cannot stall.
module prefix_gated_source_tag_classifier_core #(
  parameter int CLIENT_ENTRIES = 64,
  parameter int PREFIX_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pgstc_pkg::req_t   in_req,
  output logic              out_valid,
  output pgstc_pkg::res_t   out_res
);
  localparam int CAW = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam int PAW = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;
  localparam int CCW = $clog2(CLIENT_ENTRIES + 1);
  localparam int PCW = $clog2(PREFIX_ENTRIES + 1);
  localparam int IW  = (CCW > PCW) ? CCW : PCW;
  localparam int EW  = $bits(pgstc_pkg::entry_t);

  pgstc_pkg::state_t state_r, state_nxt;
  pgstc_pkg::req_t   req_r;
  logic [CCW-1:0]    ccount_r, ccount_nxt;
  logic [PCW-1:0]    pcount_r, pcount_nxt;
  // Scan index; wide enough to reach either count.
  logic [IW-1:0]     idx_r, idx_nxt;
  // Read data for the address issued last cycle is valid when rd_v_r is set.
  logic              rd_v_r, rd_v_nxt;
  pgstc_pkg::res_t   res_r, res_nxt;
  logic              ov_r, ov_nxt;

  pgstc_pkg::entry_t crd, prd, wentry;
  logic              cwe, pwe;
  logic [CAW-1:0]    craddr, cwaddr;
  logic [PAW-1:0]    praddr, pwaddr;
  logic              v6, is_v4, fam_ok;
  logic [127:0]      src_n, dst_n;
  logic              chit, phit, pdup;
  logic [7:0]        plen;

  assign v6     = (req_r.family == pgstc_pkg::FAM_V6);
  assign is_v4  = (req_r.family == pgstc_pkg::FAM_V4);
  assign fam_ok = v6 || is_v4;
  // IPv4 keeps only the low 32 bits of each address.
  assign src_n = is_v4 ? {96'd0, req_r.src_addr_lo[31:0]}
                       : {req_r.src_addr_hi, req_r.src_addr_lo};
  assign dst_n = is_v4 ? {96'd0, req_r.dst_addr_lo[31:0]}
                       : {req_r.dst_addr_hi, req_r.dst_addr_lo};

  assign craddr = idx_r[CAW-1:0];
  assign praddr = idx_r[PAW-1:0];
  assign cwaddr = ccount_r[CAW-1:0];
  assign pwaddr = pcount_r[PAW-1:0];
  assign wentry = '{addr_hi: src_n[127:64], addr_lo: src_n[63:0], is_v6: v6,
                    num: req_r.number};

  pgstc_ram #(.WIDTH(EW), .DEPTH(CLIENT_ENTRIES)) u_client_ram (
    .clk(clk), .we(cwe), .waddr(cwaddr), .wdata(wentry), .raddr(craddr), .rdata(crd));
  pgstc_ram #(.WIDTH(EW), .DEPTH(PREFIX_ENTRIES)) u_prefix_ram (
    .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(wentry), .raddr(praddr), .rdata(prd));

  // Compare logic on the registered read data.
  assign chit = (crd.is_v6 == v6) && ({crd.addr_hi, crd.addr_lo} == src_n);
  assign plen = prd.num[7:0];
  assign phit = (prd.is_v6 == v6) &&
                pgstc_pkg::prefix_hit(v6, dst_n, {prd.addr_hi, prd.addr_lo}, plen);
  assign pdup = (prd.is_v6 == v6) && (prd.num == req_r.number) &&
                ({prd.addr_hi, prd.addr_lo} == src_n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pgstc_pkg::S_IDLE;
      ccount_r <= '0;
      pcount_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ccount_r <= ccount_nxt;
      pcount_r <= pcount_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req_r <= in_req;
    idx_r   <= idx_nxt;
    rd_v_r  <= rd_v_nxt;
    res_r   <= res_nxt;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pgstc_pkg::S_IDLE: if (start) begin
        unique case (in_req.func)
          pgstc_pkg::FUNC_CLASSIFY: state_nxt = pgstc_pkg::S_PSCAN;
          pgstc_pkg::FUNC_ADD_CLIENT: state_nxt = pgstc_pkg::S_CSCAN;
          pgstc_pkg::FUNC_ADD_PREFIX: state_nxt = pgstc_pkg::S_PSCAN;
          pgstc_pkg::FUNC_CLEAR: state_nxt = pgstc_pkg::S_DONE;
          default: state_nxt = pgstc_pkg::S_DONE;
        endcase
      end
      pgstc_pkg::S_PSCAN: begin
        priority if (req_r.func == pgstc_pkg::FUNC_CLASSIFY &&
                     (!req_r.from_lan_edge || !fam_ok))
          state_nxt = pgstc_pkg::S_DONE;
        else if (req_r.func == pgstc_pkg::FUNC_ADD_PREFIX &&
                 (pcount_r == PCW'(PREFIX_ENTRIES) || !fam_ok ||
                  req_r.number > (v6 ? pgstc_pkg::V6_MAX_LEN : pgstc_pkg::V4_MAX_LEN)))
          state_nxt = pgstc_pkg::S_DONE;
        else if (rd_v_r && (req_r.func == pgstc_pkg::FUNC_CLASSIFY ? phit : pdup))
          state_nxt = pgstc_pkg::S_DONE;
        else if (idx_r[PCW-1:0] >= pcount_r && !rd_v_r) begin
          state_nxt = (req_r.func == pgstc_pkg::FUNC_CLASSIFY) ?
                      pgstc_pkg::S_CSCAN : pgstc_pkg::S_WRITE;
        end else if (idx_r[PCW-1:0] >= pcount_r && rd_v_r)
          state_nxt = (req_r.func == pgstc_pkg::FUNC_CLASSIFY) ?
                      pgstc_pkg::S_CSCAN : pgstc_pkg::S_WRITE;
        else
          state_nxt = state_r;
      end
      pgstc_pkg::S_CSCAN: begin
        priority if (req_r.func == pgstc_pkg::FUNC_ADD_CLIENT &&
                     (ccount_r == CCW'(CLIENT_ENTRIES) ||
                      req_r.number == 16'd0 || !fam_ok))
          state_nxt = pgstc_pkg::S_DONE;
        else if (rd_v_r && chit)
          state_nxt = pgstc_pkg::S_DONE;
        else if (idx_r[CCW-1:0] >= ccount_r)
          state_nxt = (req_r.func == pgstc_pkg::FUNC_CLASSIFY) ?
                      pgstc_pkg::S_DONE : pgstc_pkg::S_WRITE;
        else
          state_nxt = state_r;
      end
      pgstc_pkg::S_WRITE: state_nxt = pgstc_pkg::S_DONE;
      pgstc_pkg::S_DONE: state_nxt = pgstc_pkg::S_IDLE;
      default: state_nxt = pgstc_pkg::S_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    idx_nxt    = idx_r;
    rd_v_nxt   = 1'b0;
    res_nxt    = res_r;
    ccount_nxt = ccount_r;
    pcount_nxt = pcount_r;
    ov_nxt     = 1'b0;
    cwe        = 1'b0;
    pwe        = 1'b0;
    busy       = (state_r != pgstc_pkg::S_IDLE);
    unique case (state_r)
      pgstc_pkg::S_IDLE: begin
        idx_nxt   = '0;
        res_nxt   = '0;
      end
      pgstc_pkg::S_PSCAN: begin
        // Issue reads while the index is below the count; the state bail-outs
        // are handled by next-state logic, here only results are set.
        if (idx_r[PCW-1:0] < pcount_r) begin
          idx_nxt  = idx_r + 1'b1;
          rd_v_nxt = 1'b1;
        end
        if (req_r.func == pgstc_pkg::FUNC_ADD_PREFIX) begin
          priority if (pcount_r == PCW'(PREFIX_ENTRIES)) res_nxt.status = pgstc_pkg::ST_FULL;
          else if (!fam_ok || req_r.number >
                   (v6 ? pgstc_pkg::V6_MAX_LEN : pgstc_pkg::V4_MAX_LEN))
            res_nxt.status = pgstc_pkg::ST_BAD;
          else if (rd_v_r && pdup) res_nxt.status = pgstc_pkg::ST_DUP;
          else res_nxt.status = pgstc_pkg::ST_OK;
        end else if (req_r.from_lan_edge && fam_ok && rd_v_r && phit) begin
          res_nxt.dest_local = 1'b1;
        end
        if (state_nxt == pgstc_pkg::S_CSCAN) begin
          idx_nxt  = '0;
          rd_v_nxt = 1'b0;
        end
      end
      pgstc_pkg::S_CSCAN: begin
        if (idx_r[CCW-1:0] < ccount_r) begin
          idx_nxt  = idx_r + 1'b1;
          rd_v_nxt = 1'b1;
        end
        if (req_r.func == pgstc_pkg::FUNC_ADD_CLIENT) begin
          priority if (ccount_r == CCW'(CLIENT_ENTRIES)) res_nxt.status = pgstc_pkg::ST_FULL;
          else if (req_r.number == 16'd0 || !fam_ok) res_nxt.status = pgstc_pkg::ST_BAD;
          else if (rd_v_r && chit) res_nxt.status = pgstc_pkg::ST_DUP;
          else res_nxt.status = pgstc_pkg::ST_OK;
        end else if (rd_v_r && chit) begin
          res_nxt.qos_tag = crd.num;
          res_nxt.tag_write = (crd.num != 16'd0) && req_r.flow_tracked;
          res_nxt.write_reply_field = (crd.num != 16'd0) && req_r.flow_tracked &&
                                      req_r.reply_direction;
        end
        // The read still in flight when the index reaches the count is checked in
        // the cycle that leaves the scan.
      end
      pgstc_pkg::S_WRITE: begin
        if (req_r.func == pgstc_pkg::FUNC_ADD_CLIENT) begin
          cwe        = 1'b1;
          ccount_nxt = ccount_r + 1'b1;
        end else begin
          pwe        = 1'b1;
          pcount_nxt = pcount_r + 1'b1;
        end
      end
      pgstc_pkg::S_DONE: begin
        ov_nxt = 1'b1;
        if (req_r.func == pgstc_pkg::FUNC_CLEAR) begin
          ccount_nxt = '0;
          pcount_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_res   = res_r;

  // Counts never exceed table depths.
  a_ccount: assert property (@(posedge clk) disable iff (!rst_n)
    ccount_r <= CCW'(CLIENT_ENTRIES)) else $error("client count overflow");
  a_pcount: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= PCW'(PREFIX_ENTRIES)) else $error("prefix count overflow");
  // A result strobe follows the done state.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == pgstc_pkg::S_DONE)) else $error("stray strobe");
  // Rejected loads never report a tag.
  a_tagonly: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != pgstc_pkg::ST_OK) |-> (out_res.qos_tag == 16'd0))
    else $error("tag on rejected load");
endmodule

// ===== hdl/pgstc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pgstc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/sv/pgstc_checker.sv =====
// Checker for the prefix-gated source tag classifier: predicts each result from
// accepted requests with its own copy of both tables. Depends on pgstc_pkg.
module pgstc_checker #(
  parameter int CLIENT_ENTRIES = 64,
  parameter int PREFIX_ENTRIES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  pgstc_pkg::req_t in_req,
  input  logic            out_valid,
  input  pgstc_pkg::res_t out_res,
  output int              fail_count,
  output int              pending,
  output int              results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        v6;
    logic [15:0] num;
  } slot_t;

  slot_t clients[CLIENT_ENTRIES];
  slot_t prefixes[PREFIX_ENTRIES];
  int    n_clients;
  int    n_prefixes;
  pgstc_pkg::res_t expected_results[$];

  initial pending = 0;

  function automatic logic covers(logic v6, logic [63:0] ahi, logic [63:0] alo,
                                  slot_t p);
    logic [127:0] mask;
    logic [127:0] diff;
    int           len;
    len  = p.num;
    diff = {ahi, alo} ^ {p.hi, p.lo};
    if (len == 0) return 1'b1;
    if (!v6) begin
      mask = 128'hFFFF_FFFF << (32 - len);
      return ((diff & mask) & 128'hFFFF_FFFF) == 0;
    end
    mask = ~128'd0 << (128 - len);
    return (diff & mask) == 0;
  endfunction

  function automatic pgstc_pkg::res_t classify_and_load(pgstc_pkg::req_t r);
    pgstc_pkg::res_t res;
    logic            v6;
    logic [63:0]     shi, slo, dhi, dlo;
    int              lim;
    res = '0;
    v6  = (r.family == pgstc_pkg::FAM_V6);
    shi = r.src_addr_hi; slo = r.src_addr_lo;
    dhi = r.dst_addr_hi; dlo = r.dst_addr_lo;
    if (r.family == pgstc_pkg::FAM_V4) begin
      shi = '0; dhi = '0; slo[63:32] = '0; dlo[63:32] = '0;
    end
    case (r.func)
      pgstc_pkg::FUNC_CLASSIFY: begin
        if (r.from_lan_edge && r.family <= pgstc_pkg::FAM_V6) begin
          for (int i = 0; i < n_prefixes; i++)
            if (prefixes[i].v6 == v6 && covers(v6, dhi, dlo, prefixes[i])) begin
              res.dest_local = 1'b1;
              break;
            end
          if (!res.dest_local)
            for (int i = 0; i < n_clients; i++)
              if (clients[i].v6 == v6 && clients[i].hi == shi && clients[i].lo == slo) begin
                res.qos_tag = clients[i].num;
                break;
              end
          if (res.qos_tag != 0 && r.flow_tracked) begin
            res.tag_write = 1'b1;
            res.write_reply_field = r.reply_direction;
          end
        end
      end
      pgstc_pkg::FUNC_ADD_CLIENT: begin
        if (n_clients >= CLIENT_ENTRIES) res.status = pgstc_pkg::ST_FULL;
        else if (r.number == 0 || r.family > pgstc_pkg::FAM_V6) res.status = pgstc_pkg::ST_BAD;
        else begin
          for (int i = 0; i < n_clients; i++)
            if (clients[i].v6 == v6 && clients[i].hi == shi && clients[i].lo == slo)
              res.status = pgstc_pkg::ST_DUP;
          if (res.status == pgstc_pkg::ST_OK) begin
            clients[n_clients] = '{shi, slo, v6, r.number};
            n_clients++;
          end
        end
      end
      pgstc_pkg::FUNC_ADD_PREFIX: begin
        lim = v6 ? 128 : 32;
        if (n_prefixes >= PREFIX_ENTRIES) res.status = pgstc_pkg::ST_FULL;
        else if (r.family > pgstc_pkg::FAM_V6 || r.number > lim) res.status = pgstc_pkg::ST_BAD;
        else begin
          for (int i = 0; i < n_prefixes; i++)
            if (prefixes[i].v6 == v6 && prefixes[i].num == r.number &&
                prefixes[i].hi == shi && prefixes[i].lo == slo)
              res.status = pgstc_pkg::ST_DUP;
          if (res.status == pgstc_pkg::ST_OK) begin
            prefixes[n_prefixes] = '{shi, slo, v6, r.number};
            n_prefixes++;
          end
        end
      end
      default: begin
        n_clients  = 0;
        n_prefixes = 0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    pgstc_pkg::res_t want;
    if (!rst_n) begin
      n_clients    = 0;
      n_prefixes   = 0;
      fail_count   = 0;
      results_seen = 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result %p", out_res);
        end else begin
          want = expected_results.pop_front();
          if (want.qos_tag !== out_res.qos_tag || want.tag_write !== out_res.tag_write ||
              want.write_reply_field !== out_res.write_reply_field ||
              want.dest_local !== out_res.dest_local || want.status !== out_res.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Result mismatch: expected %p, got %p", want, out_res);
          end
        end
      end
      if (start && !busy) expected_results.push_back(classify_and_load(in_req));
    end
    pending = expected_results.size();
  end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the classifier testbench: clock, reset, request stimulus and verdict.
// Depends on pgstc_pkg, the classifier core and pgstc_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  pgstc_pkg::req_t in_req = '0;
  pgstc_pkg::res_t out_res;
  int   fail_count, pending, results_seen;
  int   idle_cycles = 0;
  int   requests_sent = 0;
  bit   quiet_sender = 1'b0;

  // Small pools of addresses so that classify requests often hit stored entries.
  logic [63:0] pool_hi[8];
  logic [63:0] pool_lo[8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  prefix_gated_source_tag_classifier_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  pgstc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .fail_count(fail_count),
    .pending(pending), .results_seen(results_seen)
  );

  // The watchdog counts cycles in which neither a request nor a result is
  // accepted; the limit is generous next to the length of a full scan.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // Drives one request at the falling edge and holds it until the core is no longer busy.
  // Random gaps come before the request unless the sender is in its quiet stretch.
  task automatic send_request(pgstc_pkg::req_t r);
    if (!quiet_sender)
      while ($urandom_range(99) < 20) @(negedge clk);
    in_req = r;
    start  = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 1'b0;
    requests_sent++;
  endtask

  function automatic pgstc_pkg::req_t make_req(logic [1:0] f, logic [1:0] fam,
                                               logic [63:0] shi, logic [63:0] slo,
                                               logic [63:0] dhi, logic [63:0] dlo,
                                               logic [15:0] num);
    pgstc_pkg::req_t r;
    r = '0;
    r.func = f; r.family = fam; r.number = num;
    r.src_addr_hi = shi; r.src_addr_lo = slo;
    r.dst_addr_hi = dhi; r.dst_addr_lo = dlo;
    r.from_lan_edge = 1'b1; r.flow_tracked = 1'b1;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Builds a random request, mostly loads and classifies drawn from the pools.
  function automatic pgstc_pkg::req_t random_req();
    pgstc_pkg::req_t r;
    int              pick;
    r = make_req(pgstc_pkg::FUNC_CLASSIFY, 2'($urandom_range(1)),
                 pool_hi[$urandom_range(7)], pool_lo[$urandom_range(7)],
                 pool_hi[$urandom_range(7)], pool_lo[$urandom_range(7)],
                 16'($urandom_range(128)));
    pick = $urandom_range(99);
    if (pick < 25) r.func = pgstc_pkg::FUNC_ADD_CLIENT;
    else if (pick < 45) r.func = pgstc_pkg::FUNC_ADD_PREFIX;
    else if (pick < 47) r.func = pgstc_pkg::FUNC_CLEAR;
    if (r.func == pgstc_pkg::FUNC_ADD_CLIENT) r.number = 16'($urandom_range(65535));
    if (r.func == pgstc_pkg::FUNC_ADD_PREFIX && r.family == pgstc_pkg::FAM_V4)
      r.number = 16'($urandom_range(33));
    if (r.func == pgstc_pkg::FUNC_ADD_PREFIX && $urandom_range(3) == 0)
      r.number = 16'($urandom_range(4));
    if ($urandom_range(9) == 0) r.family = 2'($urandom_range(3));
    if ($urandom_range(9) == 0) r.number = 16'($urandom());
    if ($urandom_range(9) == 0) begin
      r.src_addr_hi = rand64(); r.src_addr_lo = rand64();
      r.dst_addr_hi = rand64(); r.dst_addr_lo = rand64();
    end
    r.from_lan_edge   = $urandom_range(9) != 0;
    r.flow_tracked    = $urandom_range(3) != 0;
    r.reply_direction = 1'($urandom_range(1));
    return r;
  endfunction

  initial begin
    pgstc_pkg::req_t r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int i = 0; i < 8; i++) begin
      pool_hi[i] = (i == 0) ? 64'd0 : (i == 7) ? ~64'd0 : rand64();
      pool_lo[i] = (i == 0) ? 64'd0 : (i == 7) ? ~64'd0 : rand64();
    end

    // Directed part: extremes of lengths and tags, every error status, the
    // family and edge gating cases, the ignored IPv4 upper bits, and clear.
    send_request(make_req(pgstc_pkg::FUNC_ADD_CLIENT, pgstc_pkg::FAM_V4, ~64'd0,
                          64'h1234_5678_0A00_0001, '0, '0, 16'hFFFF));
    send_request(make_req(pgstc_pkg::FUNC_ADD_CLIENT, pgstc_pkg::FAM_V4, '0,
                          64'h0A00_0001, '0, '0, 16'd5));
    send_request(make_req(pgstc_pkg::FUNC_ADD_CLIENT, pgstc_pkg::FAM_V6, ~64'd0, ~64'd0,
                          '0, '0, 16'd1));
    send_request(make_req(pgstc_pkg::FUNC_ADD_CLIENT, pgstc_pkg::FAM_V4, '0, 64'd7,
                          '0, '0, 16'd0));
    send_request(make_req(pgstc_pkg::FUNC_ADD_CLIENT, pgstc_pkg::FAM_OTHER, '0, 64'd7,
                          '0, '0, 16'd3));
    send_request(make_req(pgstc_pkg::FUNC_CLASSIFY, pgstc_pkg::FAM_V4, 64'hDEAD,
                          64'hFFFF_FFFF_0A00_0001, '0, 64'hC0A8_0001, '0));
    send_request(make_req(pgstc_pkg::FUNC_CLASSIFY, pgstc_pkg::FAM_V6, ~64'd0, ~64'd0,
                          '0, '0, '0));
    r = make_req(pgstc_pkg::FUNC_CLASSIFY, pgstc_pkg::FAM_V6, ~64'd0, ~64'd0, '0, '0, '0);
    r.reply_direction = 1'b1;
    send_request(r);
    r.flow_tracked = 1'b0;
    send_request(r);
    r.from_lan_edge = 1'b0;
    send_request(r);
    send_request(make_req(pgstc_pkg::FUNC_CLASSIFY, pgstc_pkg::FAM_RESERVED, ~64'd0,
                          ~64'd0, '0, '0, '0));
    send_request(make_req(pgstc_pkg::FUNC_ADD_PREFIX, pgstc_pkg::FAM_V4, '0,
                          64'hC0A8_0000, '0, '0, 16'd33));
    send_request(make_req(pgstc_pkg::FUNC_ADD_PREFIX, pgstc_pkg::FAM_V6, '0, '0,
                          '0, '0, 16'd129));
    send_request(make_req(pgstc_pkg::FUNC_ADD_PREFIX, pgstc_pkg::FAM_OTHER, '0, '0,
                          '0, '0, 16'd8));
    send_request(make_req(pgstc_pkg::FUNC_ADD_PREFIX, pgstc_pkg::FAM_V4, '0,
                          64'hC0A8_0000, '0, '0, 16'd16));
    send_request(make_req(pgstc_pkg::FUNC_ADD_PREFIX, pgstc_pkg::FAM_V4, '0,
                          64'hC0A8_0000, '0, '0, 16'd16));
    send_request(make_req(pgstc_pkg::FUNC_CLASSIFY, pgstc_pkg::FAM_V4, '0, 64'h0A00_0001,
                          '0, 64'hC0A8_7777, '0));
    send_request(make_req(pgstc_pkg::FUNC_ADD_PREFIX, pgstc_pkg::FAM_V6, ~64'd0, ~64'd0,
                          '0, '0, 16'd128));
    send_request(make_req(pgstc_pkg::FUNC_ADD_PREFIX, pgstc_pkg::FAM_V6, '0, '0,
                          '0, '0, 16'd0));
    send_request(make_req(pgstc_pkg::FUNC_CLASSIFY, pgstc_pkg::FAM_V6, ~64'd0, ~64'd0,
                          64'd3, 64'd4, '0));
    send_request(make_req(pgstc_pkg::FUNC_CLEAR, pgstc_pkg::FAM_V4, '0, '0, '0, '0, '0));
    send_request(make_req(pgstc_pkg::FUNC_CLASSIFY, pgstc_pkg::FAM_V6, ~64'd0, ~64'd0,
                          64'd3, 64'd4, '0));

    // Fill the client table and then the prefix table to overflow, one rejected load each.
    for (int i = 0; i < 65; i++)
      send_request(make_req(pgstc_pkg::FUNC_ADD_CLIENT, pgstc_pkg::FAM_V6, 64'(i),
                            ~64'd0 - 64'(i), '0, '0, 16'(i + 1)));
    for (int i = 0; i < 65; i++)
      send_request(make_req(pgstc_pkg::FUNC_ADD_PREFIX, pgstc_pkg::FAM_V4, '0,
                            64'(i) << 8, '0, '0, 16'd24));
    send_request(make_req(pgstc_pkg::FUNC_CLASSIFY, pgstc_pkg::FAM_V6, 64'd9,
                          ~64'd0 - 64'd9, '0, '0, '0));
    send_request(make_req(pgstc_pkg::FUNC_CLEAR, pgstc_pkg::FAM_V4, '0, '0, '0, '0, '0));

    // Hold the sender until every outstanding result has come back.
    while (pending != 0) @(negedge clk);

    for (int n = 0; n < 250; n++) begin
      quiet_sender = (n >= 100 && n < 180);
      send_request(random_req());
    end

    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("Sent %0d requests covering loads, errors, full tables, clears and",
             requests_sent);
    $display("classifies of both families; %0d results checked.", results_seen);
    if (fail_count == 0 && pending == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
